>>> rtl/core/rrts_pkg.sv
// Shared types and constants for the round-robin task scheduler.
// Used by rrts_pct_unit and round_robin_task_scheduler; no dependencies.
package rrts_pkg;

   localparam int         PCT_STEPS   = 100;
   localparam logic [6:0] PCT_FULL    = 7'd100;
   localparam logic [7:0] SLICE_RESET = 8'd5;
   localparam logic [3:0] IDLE_RESET  = 4'd1;
   localparam int         CSR_AW      = 4;

   typedef enum logic [2:0] {
      ACT_TICK   = 3'd0,
      ACT_YIELD  = 3'd1,
      ACT_CREATE = 3'd2,
      ACT_EXIT   = 3'd3,
      ACT_SAMPLE = 3'd4,
      ACT_CLEAR  = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      STAT_DONE   = 2'd0,
      STAT_SWITCH = 2'd1,
      STAT_FULL   = 2'd2,
      STAT_OFF    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      TS_UNUSED  = 2'd0,
      TS_READY   = 2'd1,
      TS_RUNNING = 2'd2,
      TS_EXITED  = 2'd3
   } task_state_type;

   typedef enum logic [1:0] {
      CSR_ENABLE = 2'd0,
      CSR_SLICE  = 2'd1,
      CSR_IDLE   = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_TICK_WR,
      S_SEL_START,
      S_SEL_WALK,
      S_SEL_PREV,
      S_SEL_FIN,
      S_CRT_NEW,
      S_CRT_LINK,
      S_EXIT_WR,
      S_PCT_START,
      S_PCT_WAIT,
      S_DONE
   } sched_state_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] space_id;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] running_slot;
      logic [3:0] new_slot;
      logic       space_change;
      logic [6:0] busy_percent;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] total_delta;
      logic [63:0] idle_delta;
   } pct_cmd_type;

   typedef struct packed {
      logic       done;
      logic [6:0] percent;
   } pct_stat_type;

endpackage

>>> rtl/core/rrts_pct_unit.sv
// Iterative busy-percent unit: one compare and add/subtract step per cycle.
// Depends on rrts_pkg.
module rrts_pct_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  rrts_pkg::pct_cmd_type  cmd,
   output rrts_pkg::pct_stat_type stat
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [63:0] busy_ff, busy_in;
   logic [63:0] gap_ff, gap_in;
   logic [63:0] rem_ff, rem_in;
   logic [6:0]  res_ff, res_in;
   logic [6:0]  step_ff, step_in;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      busy_in = busy_ff;
      gap_in  = gap_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      step_in = step_ff;
      if (cmd.start) begin
         busy_in = cmd.total_delta - cmd.idle_delta;
         gap_in  = cmd.idle_delta;
         rem_in  = '0;
         step_in = 7'(rrts_pkg::PCT_STEPS);
         if ((cmd.total_delta > cmd.idle_delta) && (cmd.idle_delta != '0)) begin
            run_in = 1'b1;
            res_in = '0;
         end else begin
            done_in = 1'b1;
            res_in  = (cmd.total_delta > cmd.idle_delta) ? rrts_pkg::PCT_FULL : '0;
         end
      end else if (run_ff) begin
         if (rem_ff >= gap_ff) begin
            rem_in = rem_ff - gap_ff;
            res_in = res_ff + 7'd1;
         end else begin
            rem_in = rem_ff + busy_ff;
         end
         step_in = step_ff - 7'd1;
         if (step_ff == 7'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      busy_ff <= busy_in;
      gap_ff  <= gap_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      step_ff <= step_in;
   end

   assign stat = {done_ff, res_ff};

endmodule

>>> rtl/core/round_robin_task_scheduler.sv
// Round-robin time-slice task scheduler: task table memory, ring walk, usage counters.
// Tick and exit write back the running entry; create writes the new entry, then links it after
// the head; sample runs the 100-step percent unit unless the result is trivial. Selection walks
// the ring entry by entry (up to MAX_TASKS) and, on a switch, writes the new running entry and,
// unless it exited, the old one. One item at a time; a result not yet taken holds the block in its done state.
// Synchronous reset, no clearing pass (fill count, slot-zero flag). Uses rrts_pkg, rrts_pct_unit.
module round_robin_task_scheduler #(
   parameter int MAX_TASKS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  rrts_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rrts_pkg::rsp_type                 rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rrts_pkg::CSR_AW-1:0]       paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   localparam int SW = $clog2(MAX_TASKS);
   localparam int CW = $clog2(MAX_TASKS + 1);

   typedef struct packed {
      rrts_pkg::task_state_type state;
      logic [SW-1:0]            next;
      logic [7:0]               slice;
      logic [7:0]               space;
   } entry_type;

   localparam entry_type SLOT0_RESET = '{
      state: rrts_pkg::TS_RUNNING, next: '0, slice: '0, space: '0};

   rrts_pkg::sched_state_type state_ff, state_in;

   logic                 enable_ff, enable_in;
   logic [7:0]           slice_ticks_ff, slice_ticks_in;
   logic [3:0]           idle_slot_ff, idle_slot_in;

   logic [SW-1:0]        running_ff, running_in;
   logic [SW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [63:0]          total_ff, total_in;
   logic [63:0]          idle_ff, idle_in;
   logic [63:0]          stotal_ff, stotal_in;
   logic [63:0]          sidle_ff, sidle_in;

   logic [2:0]           act_ff, act_in;
   logic [7:0]           space_ff, space_in;
   rrts_pkg::status_type status_ff, status_in;
   logic                 chg_ff, chg_in;
   logic [3:0]           new_ff, new_in;
   logic [6:0]           pct_ff, pct_in;

   logic [SW-1:0]        start_ff, start_in;
   logic [SW-1:0]        cand_ff, cand_in;
   entry_type            hold_ff, hold_in;
   logic [63:0]          dt_ff, dt_in;
   logic [63:0]          di_ff, di_in;

   rrts_pkg::rsp_type    rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   entry_type            task_mem [MAX_TASKS];
   entry_type            rd_ff;
   logic                 rd_rst_ff;
   logic                 slot0_ff, slot0_in;
   entry_type            rd_ent;
   logic [SW-1:0]        rd_addr;
   logic                 wr_en;
   logic [SW-1:0]        wr_addr;
   entry_type            wr_data;

   rrts_pkg::pct_cmd_type  pct_cmd;
   rrts_pkg::pct_stat_type pct_stat;

   logic req_accept;
   logic rsp_load;
   logic csr_write;
   logic table_full;

   assign req_accept = req_valid && req_ready;
   assign rsp_load   = (state_ff == rrts_pkg::S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign csr_write  = psel && penable && pwrite;
   assign table_full = (count_ff == CW'(MAX_TASKS));
   assign rd_ent     = rd_rst_ff ? SLOT0_RESET : rd_ff;

   rrts_pct_unit u_pct (
      .clock (clock),
      .reset (reset),
      .cmd   (pct_cmd),
      .stat  (pct_stat)
   );

   // task table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         task_mem[wr_addr] <= wr_data;
      end
      rd_ff     <= task_mem[rd_addr];
      rd_rst_ff <= (rd_addr == '0) && !slot0_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrts_pkg::S_IDLE: begin
            if (req_accept) state_in = rrts_pkg::S_DISPATCH;
         end
         rrts_pkg::S_DISPATCH: begin
            case (act_ff)
               rrts_pkg::ACT_TICK:   state_in = enable_ff ? rrts_pkg::S_TICK_WR
                                                          : rrts_pkg::S_DONE;
               rrts_pkg::ACT_YIELD:  state_in = enable_ff ? rrts_pkg::S_SEL_START
                                                          : rrts_pkg::S_DONE;
               rrts_pkg::ACT_CREATE: state_in = table_full ? rrts_pkg::S_DONE
                                                           : rrts_pkg::S_CRT_NEW;
               rrts_pkg::ACT_EXIT:   state_in = rrts_pkg::S_EXIT_WR;
               rrts_pkg::ACT_SAMPLE: state_in = rrts_pkg::S_PCT_START;
               default:              state_in = rrts_pkg::S_DONE;
            endcase
         end
         rrts_pkg::S_TICK_WR: begin
            state_in = (rd_ent.slice <= 8'd1) ? rrts_pkg::S_SEL_START : rrts_pkg::S_DONE;
         end
         rrts_pkg::S_SEL_START: state_in = rrts_pkg::S_SEL_WALK;
         rrts_pkg::S_SEL_WALK: begin
            if (rd_ent.state == rrts_pkg::TS_READY) begin
               state_in = (cand_ff == running_ff) ? rrts_pkg::S_DONE : rrts_pkg::S_SEL_PREV;
            end else if (rd_ent.next == start_ff) begin
               state_in = rrts_pkg::S_DONE;
            end
         end
         rrts_pkg::S_SEL_PREV:  state_in = rrts_pkg::S_SEL_FIN;
         rrts_pkg::S_SEL_FIN:   state_in = rrts_pkg::S_DONE;
         rrts_pkg::S_CRT_NEW:   state_in = rrts_pkg::S_CRT_LINK;
         rrts_pkg::S_CRT_LINK:  state_in = rrts_pkg::S_DONE;
         rrts_pkg::S_EXIT_WR:   state_in = rrts_pkg::S_DONE;
         rrts_pkg::S_PCT_START: state_in = rrts_pkg::S_PCT_WAIT;
         rrts_pkg::S_PCT_WAIT: begin
            if (pct_stat.done) state_in = rrts_pkg::S_DONE;
         end
         rrts_pkg::S_DONE: begin
            if (rsp_load) state_in = rrts_pkg::S_IDLE;
         end
         default: state_in = rrts_pkg::S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      enable_in      = enable_ff;
      slice_ticks_in = slice_ticks_ff;
      idle_slot_in   = idle_slot_ff;
      running_in     = running_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      total_in       = total_ff;
      idle_in        = idle_ff;
      stotal_in      = stotal_ff;
      sidle_in       = sidle_ff;
      act_in         = act_ff;
      space_in       = space_ff;
      status_in      = status_ff;
      chg_in         = chg_ff;
      new_in         = new_ff;
      pct_in         = pct_ff;
      start_in       = start_ff;
      cand_in        = cand_ff;
      hold_in        = hold_ff;
      dt_in          = dt_ff;
      di_in          = di_ff;
      rd_addr        = running_ff;
      wr_en          = 1'b0;
      wr_addr        = running_ff;
      wr_data        = rd_ent;
      pct_cmd        = {1'b0, dt_ff, di_ff};

      case (state_ff)
         rrts_pkg::S_IDLE: begin
            if (req_accept) begin
               act_in    = req_data.action;
               space_in  = req_data.space_id;
               status_in = rrts_pkg::STAT_DONE;
               chg_in    = 1'b0;
               new_in    = '0;
               pct_in    = '0;
            end
         end
         rrts_pkg::S_DISPATCH: begin
            case (act_ff)
               rrts_pkg::ACT_TICK: begin
                  if (!enable_ff) begin
                     status_in = rrts_pkg::STAT_OFF;
                  end else begin
                     total_in = total_ff + 64'd1;
                     if (32'(running_ff) == 32'(idle_slot_ff)) idle_in = idle_ff + 64'd1;
                  end
               end
               rrts_pkg::ACT_YIELD: begin
                  if (!enable_ff) status_in = rrts_pkg::STAT_OFF;
                  rd_addr = head_ff;
               end
               rrts_pkg::ACT_CREATE: begin
                  if (table_full) status_in = rrts_pkg::STAT_FULL;
                  rd_addr = head_ff;
               end
               rrts_pkg::ACT_SAMPLE: begin
                  dt_in     = total_ff - stotal_ff;
                  di_in     = idle_ff - sidle_ff;
                  stotal_in = total_ff;
                  sidle_in  = idle_ff;
               end
               rrts_pkg::ACT_CLEAR: begin
                  total_in = '0;
                  idle_in  = '0;
               end
               default: ;
            endcase
         end
         rrts_pkg::S_TICK_WR: begin
            wr_en   = 1'b1;
            rd_addr = head_ff;
            if (rd_ent.slice <= 8'd1) begin
               wr_data.slice = slice_ticks_ff;
            end else begin
               wr_data.slice = rd_ent.slice - 8'd1;
            end
         end
         rrts_pkg::S_SEL_START: begin
            start_in = rd_ent.next;
            cand_in  = rd_ent.next;
            rd_addr  = rd_ent.next;
         end
         rrts_pkg::S_SEL_WALK: begin
            if (rd_ent.state == rrts_pkg::TS_READY) begin
               if (cand_ff == running_ff) begin
                  wr_en         = 1'b1;
                  wr_addr       = cand_ff;
                  wr_data.slice = slice_ticks_ff;
               end else begin
                  hold_in = rd_ent;
               end
            end else begin
               cand_in = rd_ent.next;
               rd_addr = rd_ent.next;
            end
         end
         rrts_pkg::S_SEL_PREV: begin
            chg_in        = (hold_ff.space != 8'd0) && (hold_ff.space != rd_ent.space);
            wr_en         = 1'b1;
            wr_addr       = cand_ff;
            wr_data       = hold_ff;
            wr_data.state = rrts_pkg::TS_RUNNING;
            hold_in       = rd_ent;
         end
         rrts_pkg::S_SEL_FIN: begin
            wr_en         = (hold_ff.state == rrts_pkg::TS_RUNNING);
            wr_addr       = running_ff;
            wr_data       = hold_ff;
            wr_data.state = rrts_pkg::TS_READY;
            running_in    = cand_ff;
            head_in       = cand_ff;
            status_in     = rrts_pkg::STAT_SWITCH;
         end
         rrts_pkg::S_CRT_NEW: begin
            hold_in       = rd_ent;
            wr_en         = 1'b1;
            wr_addr       = count_ff[SW-1:0];
            wr_data.state = rrts_pkg::TS_READY;
            wr_data.next  = rd_ent.next;
            wr_data.slice = slice_ticks_ff;
            wr_data.space = space_ff;
         end
         rrts_pkg::S_CRT_LINK: begin
            wr_en        = 1'b1;
            wr_addr      = head_ff;
            wr_data      = hold_ff;
            wr_data.next = count_ff[SW-1:0];
            count_in     = count_ff + CW'(1);
            new_in       = 4'(count_ff);
         end
         rrts_pkg::S_EXIT_WR: begin
            wr_en         = 1'b1;
            wr_data.state = rrts_pkg::TS_EXITED;
         end
         rrts_pkg::S_PCT_START: begin
            pct_cmd = {1'b1, dt_ff, di_ff};
         end
         rrts_pkg::S_PCT_WAIT: begin
            if (pct_stat.done) pct_in = pct_stat.percent;
         end
         default: ;
      endcase

      if (csr_write) begin
         case (paddr[3:2])
            rrts_pkg::CSR_ENABLE: enable_in      = pwdata[0];
            rrts_pkg::CSR_SLICE:  slice_ticks_in = pwdata[7:0];
            rrts_pkg::CSR_IDLE:   idle_slot_in   = pwdata[3:0];
            default: ;
         endcase
      end
   end

   assign slot0_in = slot0_ff || (wr_en && (wr_addr == '0));

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (rsp_load) begin
         rsp_in       = {status_ff, 4'(running_ff), new_ff, chg_ff, pct_ff};
         rsp_valid_in = 1'b1;
      end
   end

   always_comb begin
      case (paddr[3:2])
         rrts_pkg::CSR_ENABLE: prdata = {31'd0, enable_ff};
         rrts_pkg::CSR_SLICE:  prdata = {24'd0, slice_ticks_ff};
         rrts_pkg::CSR_IDLE:   prdata = {28'd0, idle_slot_ff};
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= rrts_pkg::S_IDLE;
         enable_ff      <= 1'b0;
         slice_ticks_ff <= rrts_pkg::SLICE_RESET;
         idle_slot_ff   <= rrts_pkg::IDLE_RESET;
         running_ff     <= '0;
         head_ff        <= '0;
         count_ff       <= CW'(1);
         total_ff       <= '0;
         idle_ff        <= '0;
         stotal_ff      <= '0;
         sidle_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         slot0_ff       <= 1'b0;
      end else begin
         state_ff       <= state_in;
         enable_ff      <= enable_in;
         slice_ticks_ff <= slice_ticks_in;
         idle_slot_ff   <= idle_slot_in;
         running_ff     <= running_in;
         head_ff        <= head_in;
         count_ff       <= count_in;
         total_ff       <= total_in;
         idle_ff        <= idle_in;
         stotal_ff      <= stotal_in;
         sidle_ff       <= sidle_in;
         rsp_valid_ff   <= rsp_valid_in;
         slot0_ff       <= slot0_in;
      end
      act_ff    <= act_in;
      space_ff  <= space_in;
      status_ff <= status_in;
      chg_ff    <= chg_in;
      new_ff    <= new_in;
      pct_ff    <= pct_in;
      start_ff  <= start_in;
      cand_ff   <= cand_in;
      hold_ff   <= hold_in;
      dt_ff     <= dt_in;
      di_ff     <= di_in;
      rsp_ff    <= rsp_in;
   end

   assign req_ready = (state_ff == rrts_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pready    = 1'b1;

   // running task always heads the ring
   a_head_running: assert property (@(posedge clock) disable iff (reset)
      running_ff == head_ff)
      else $error("ring head differs from running task");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (count_ff <= CW'(MAX_TASKS)))
      else $error("task count out of range");

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == rrts_pkg::S_DISPATCH))
      else $error("accepted transfer not dispatched");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      pct_stat.done |-> (pct_stat.percent <= rrts_pkg::PCT_FULL))
      else $error("busy percent above full scale");

endmodule

>>> dv/round_robin_task_scheduler_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for round_robin_task_scheduler: request and response streams with
// random stalls, APB register writes, and a task table model that predicts every response.
// Depends on rrts_pkg and the scheduler RTL.
module round_robin_task_scheduler_test;

   localparam int NSLOTS           = 16;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int END_WAIT         = 40;
   localparam int RANDOM_PER_PHASE = 340;
   localparam int CHUNKS_PER_PHASE = 4;
   localparam int MAX_PRINTED      = 50;
   localparam logic [127:0] PERCENT_SCALE = 128'd100;
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   rrts_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rrts_pkg::rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [rrts_pkg::CSR_AW-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   round_robin_task_scheduler #(.MAX_TASKS(NSLOTS)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // task table model
   rrts_pkg::task_state_type slot_state [NSLOTS];
   logic [3:0] slot_link [NSLOTS];
   logic [7:0] slot_slice [NSLOTS];
   logic [7:0] slot_space [NSLOTS];
   logic [3:0] cur_slot;
   logic [3:0] head_slot;
   logic [63:0] tick_total;
   logic [63:0] tick_idle;
   logic [63:0] mark_total;
   logic [63:0] mark_idle;
   logic enable_cfg;
   logic [7:0] slice_cfg;
   logic [3:0] idle_cfg;

   rrts_pkg::rsp_type pending_results [$];

   int send_idle_pct = 27;
   int recv_idle_pct = 82;
   int fail_count = 0;
   int items_sent = 0;
   int results_seen = 0;
   int switch_count = 0;
   int sample_count = 0;
   int config_writes = 0;
   int quiet_cycles = 0;

   initial forever #4 clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want);
      fail_count++;
      if (fail_count <= MAX_PRINTED)
         $display("mismatch, %s: got %0d, expected %0d (response %0d)",
                  what, got, want, results_seen);
   endtask

   task automatic table_reset();
      for (int s = 0; s < NSLOTS; s++) begin
         slot_state[s] = rrts_pkg::TS_UNUSED;
         slot_link[s]  = '0;
         slot_slice[s] = '0;
         slot_space[s] = '0;
      end
      slot_state[0] = rrts_pkg::TS_RUNNING;
      cur_slot   = '0;
      head_slot  = '0;
      tick_total = '0;
      tick_idle  = '0;
      mark_total = '0;
      mark_idle  = '0;
      enable_cfg = 1'b0;
      slice_cfg  = rrts_pkg::SLICE_RESET;
      idle_cfg   = rrts_pkg::IDLE_RESET;
   endtask

   function automatic int live_tasks();
      int n;
      n = 0;
      for (int s = 0; s < NSLOTS; s++)
         if (slot_state[s] == rrts_pkg::TS_READY || slot_state[s] == rrts_pkg::TS_RUNNING)
            n++;
      return n;
   endfunction

   function automatic bit table_has_room();
      bit room;
      room = 1'b0;
      for (int s = 0; s < NSLOTS; s++)
         if (slot_state[s] == rrts_pkg::TS_UNUSED) room = 1'b1;
      return room;
   endfunction

   function automatic logic [7:0] random_space();
      logic [7:0] space;
      case ($urandom_range(0, 3))
         0: space = 8'h00;
         1: space = 8'h5A;
         default: space = 8'($urandom_range(0, 255));
      endcase
      return space;
   endfunction

   // walk from the entry after the head to the first ready task
   task automatic rotate_ring(output rrts_pkg::status_type st, output logic moved);
      logic [3:0] start_slot;
      logic [3:0] cand;
      logic [3:0] prev;
      start_slot = slot_link[head_slot];
      cand = start_slot;
      prev = cur_slot;
      moved = 1'b0;
      st = rrts_pkg::STAT_DONE;
      for (int i = 0; i < NSLOTS; i++) begin
         if (slot_state[cand] == rrts_pkg::TS_READY) break;
         cand = slot_link[cand];
         if (cand == start_slot) break;
      end
      if (slot_state[cand] == rrts_pkg::TS_READY) begin
         if (cand == prev) begin
            slot_slice[cand] = slice_cfg;
         end else begin
            moved = (slot_space[cand] != 8'd0) && (slot_space[cand] != slot_space[prev]);
            slot_state[cand] = rrts_pkg::TS_RUNNING;
            if (slot_state[prev] == rrts_pkg::TS_RUNNING) slot_state[prev] = rrts_pkg::TS_READY;
            cur_slot  = cand;
            head_slot = cand;
            st = rrts_pkg::STAT_SWITCH;
         end
      end
   endtask

   task automatic schedule_step(input rrts_pkg::req_type item);
      rrts_pkg::rsp_type want;
      rrts_pkg::status_type st;
      logic moved;
      int s;
      logic [63:0] dt;
      logic [63:0] di;
      logic [63:0] busy;
      logic [127:0] scaled;
      want = '0;
      st = rrts_pkg::STAT_DONE;
      moved = 1'b0;
      case (item.action)
         rrts_pkg::ACT_TICK: begin
            if (!enable_cfg) begin
               st = rrts_pkg::STAT_OFF;
            end else begin
               tick_total = tick_total + 64'd1;
               if (cur_slot == idle_cfg) tick_idle = tick_idle + 64'd1;
               if (slot_slice[cur_slot] <= 8'd1) begin
                  slot_slice[cur_slot] = slice_cfg;
                  rotate_ring(st, moved);
               end else begin
                  slot_slice[cur_slot] = slot_slice[cur_slot] - 8'd1;
               end
            end
         end
         rrts_pkg::ACT_YIELD: begin
            if (!enable_cfg) st = rrts_pkg::STAT_OFF;
            else rotate_ring(st, moved);
         end
         rrts_pkg::ACT_CREATE: begin
            s = 0;
            while (s < NSLOTS && slot_state[s] != rrts_pkg::TS_UNUSED) s++;
            if (s >= NSLOTS) begin
               st = rrts_pkg::STAT_FULL;
            end else begin
               slot_state[s] = rrts_pkg::TS_READY;
               slot_slice[s] = slice_cfg;
               slot_space[s] = item.space_id;
               slot_link[s] = slot_link[head_slot];
               slot_link[head_slot] = 4'(s);
               want.new_slot = 4'(s);
            end
         end
         rrts_pkg::ACT_EXIT: slot_state[cur_slot] = rrts_pkg::TS_EXITED;
         rrts_pkg::ACT_SAMPLE: begin
            sample_count++;
            dt = tick_total - mark_total;
            di = tick_idle - mark_idle;
            mark_total = tick_total;
            mark_idle  = tick_idle;
            if (dt != 64'd0) begin
               busy = (dt > di) ? dt - di : 64'd0;
               scaled = ({64'd0, busy} * PERCENT_SCALE) / {64'd0, dt};
               want.busy_percent = scaled[6:0];
            end
         end
         rrts_pkg::ACT_CLEAR: begin
            tick_total = '0;
            tick_idle  = '0;
         end
         default: ;
      endcase
      want.status = st;
      want.running_slot = cur_slot;
      want.space_change = moved;
      if (st == rrts_pkg::STAT_SWITCH) switch_count++;
      pending_results.push_back(want);
   endtask

   task automatic send_item(input logic [2:0] action, input logic [7:0] space);
      rrts_pkg::req_type item;
      item.action = action;
      item.space_id = space;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      schedule_step(item);
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input rrts_pkg::csr_index_type idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      case (idx)
         rrts_pkg::CSR_ENABLE: enable_cfg = value[0];
         rrts_pkg::CSR_SLICE:  slice_cfg = value[7:0];
         rrts_pkg::CSR_IDLE:   idle_cfg = value[3:0];
         default: ;
      endcase
      config_writes++;
   endtask

   // scheduler still off after reset
   task automatic test_disabled_actions();
      send_item(rrts_pkg::ACT_TICK, 8'h00);
      send_item(rrts_pkg::ACT_YIELD, 8'hFF);
      send_item(rrts_pkg::ACT_CREATE, 8'h00);
      send_item(rrts_pkg::ACT_CREATE, 8'hFF);
      send_item(rrts_pkg::ACT_EXIT, 8'h00);
      send_item(ACT_SPARE_6, 8'hA5);
      send_item(ACT_SPARE_7, 8'h5A);
      send_item(rrts_pkg::ACT_SAMPLE, 8'h00);
      send_item(rrts_pkg::ACT_CLEAR, 8'h00);
   endtask

   task automatic test_slice_extremes();
      settle_block();
      csr_write(rrts_pkg::CSR_ENABLE, 32'd1);
      csr_write(rrts_pkg::CSR_SLICE, 32'd1);
      csr_write(rrts_pkg::CSR_IDLE, 32'd0);
      repeat (4) send_item(rrts_pkg::ACT_TICK, random_space());
      send_item(rrts_pkg::ACT_YIELD, random_space());
      settle_block();
      csr_write(rrts_pkg::CSR_SLICE, 32'd0);
      repeat (3) send_item(rrts_pkg::ACT_TICK, random_space());
      settle_block();
      csr_write(rrts_pkg::CSR_SLICE, 32'd255);
      csr_write(rrts_pkg::CSR_IDLE, 32'd15);
      repeat (2) send_item(rrts_pkg::ACT_TICK, random_space());
      send_item(rrts_pkg::ACT_YIELD, random_space());
   endtask

   // idle share, counter clear and wrapped differences
   task automatic test_usage_counters();
      settle_block();
      csr_write(rrts_pkg::CSR_IDLE, {28'd0, cur_slot});
      send_item(rrts_pkg::ACT_SAMPLE, 8'h00);
      repeat (2) send_item(rrts_pkg::ACT_TICK, 8'h00);
      send_item(rrts_pkg::ACT_CLEAR, 8'h00);
      send_item(rrts_pkg::ACT_TICK, 8'h00);
      send_item(rrts_pkg::ACT_SAMPLE, 8'h00);
      send_item(rrts_pkg::ACT_SAMPLE, 8'h00);
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
      int r;
      logic [2:0] act;
      logic [31:0] slice_pick;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      for (int c = 0; c < CHUNKS_PER_PHASE; c++) begin
         settle_block();
         case ($urandom_range(0, 5))
            0: slice_pick = 32'd1;
            1: slice_pick = 32'd255;
            2: slice_pick = 32'd0;
            default: slice_pick = 32'($urandom_range(2, 6));
         endcase
         csr_write(rrts_pkg::CSR_ENABLE, 32'd1);
         csr_write(rrts_pkg::CSR_SLICE, slice_pick);
         csr_write(rrts_pkg::CSR_IDLE, 32'($urandom_range(0, 15)));
         for (int n = 0; n < RANDOM_PER_PHASE / CHUNKS_PER_PHASE; n++) begin
            r = $urandom_range(0, 199);
            if (r < 90) act = rrts_pkg::ACT_TICK;
            else if (r < 120) act = rrts_pkg::ACT_YIELD;
            else if (r < 128) act = rrts_pkg::ACT_CREATE;
            else if (r < 132)
               act = (live_tasks() >= 3) ? rrts_pkg::ACT_EXIT : rrts_pkg::ACT_TICK;
            else if (r < 150) act = rrts_pkg::ACT_SAMPLE;
            else if (r < 156) act = rrts_pkg::ACT_CLEAR;
            else if (r < 158) act = ACT_SPARE_6;
            else if (r < 160) act = ACT_SPARE_7;
            else act = rrts_pkg::ACT_TICK;
            send_item(act, random_space());
         end
      end
   endtask

   task automatic test_table_full();
      while (table_has_room()) send_item(rrts_pkg::ACT_CREATE, random_space());
      send_item(rrts_pkg::ACT_CREATE, 8'h3C);
      send_item(rrts_pkg::ACT_TICK, 8'h00);
      settle_block();
      csr_write(rrts_pkg::CSR_ENABLE, 32'd0);
      send_item(rrts_pkg::ACT_TICK, 8'h81);
      send_item(rrts_pkg::ACT_YIELD, 8'h7E);
      send_item(rrts_pkg::ACT_CREATE, 8'hC3);
      send_item(rrts_pkg::ACT_SAMPLE, 8'h00);
   endtask

   always @(posedge clock) begin : check_results
      rrts_pkg::rsp_type want;
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("response with nothing pending", rsp_data.status, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.status != want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.running_slot != want.running_slot)
               report_mismatch("running_slot", rsp_data.running_slot, want.running_slot);
            if (rsp_data.new_slot != want.new_slot)
               report_mismatch("new_slot", rsp_data.new_slot, want.new_slot);
            if (rsp_data.space_change != want.space_change)
               report_mismatch("space_change", rsp_data.space_change, want.space_change);
            if (rsp_data.busy_percent != want.busy_percent)
               report_mismatch("busy_percent", rsp_data.busy_percent, want.busy_percent);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles, %0d responses outstanding",
                  quiet_cycles, pending_results.size());
         $display("round_robin_task_scheduler_test: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      table_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_disabled_actions();
      test_slice_extremes();
      test_usage_counters();
      test_random_traffic(27, 82);
      test_random_traffic(82, 27);
      test_random_traffic(0, 0);
      test_table_full();
      settle_block();
      repeat (END_WAIT) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("responses never delivered", 0, pending_results.size());
      $display("covered %0d requests, %0d responses, %0d task switches, %0d usage samples",
               items_sent, results_seen, switch_count, sample_count);
      $display("across %0d register writes with mixed sender and receiver stalls",
               config_writes);
      if (fail_count == 0) begin
         $display("round_robin_task_scheduler_test: clean");
      end else begin
         $display("round_robin_task_scheduler_test: errors");
      end
      $finish;
   end

endmodule
